@@ rtl/core/mpsw_pkg.sv @@
package mpsw_pkg;

  typedef struct packed {
    logic               paused;
    logic               pose_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               recovery_owns;
    logic               reflex_active;
    logic               goal_active;
    logic               cmd_valid;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic [47:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic        error_level;
    logic [3:0]  reason_code;
    logic [47:0] stuck_ms;
  } out_item_t;

  // front classification of one item
  typedef enum logic [2:0] {
    CLS_PAUSED,
    CLS_RECOVERY,
    CLS_REFLEX,
    CLS_NOGOAL,
    CLS_NOCMD,
    CLS_CHECK
  } cls_t;

  typedef enum logic [3:0] {
    RSN_PROGRESS = 4'd0,
    RSN_PAUSED   = 4'd1,
    RSN_RECOVERY = 4'd2,
    RSN_REFLEX   = 4'd3,
    RSN_NOGOAL   = 4'd4,
    RSN_NOCMD    = 4'd5,
    RSN_SLOW     = 4'd6,
    RSN_NOPOSE   = 4'd7,
    RSN_STUCK    = 4'd8
  } reason_t;

  typedef struct packed {
    cls_t               cls;
    logic               pose_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic [47:0]        now_ms;
  } qent_t;

  typedef struct packed {
    logic [14:0] speed_threshold;
    logic [30:0] progress_distance;
    logic [31:0] stuck_time_limit;
  } cfg_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TIME_LIMIT  = 2'd2;

  localparam logic [14:0] SPEED_THRESHOLD_RST   = 15'd50;
  localparam logic [30:0] PROGRESS_DISTANCE_RST = 31'd100;
  localparam logic [31:0] STUCK_TIME_LIMIT_RST  = 32'd5000;
  localparam logic [29:0] SPEED_SQ_RST          = 30'd2500;
  localparam logic [61:0] DIST_SQ_RST           = 62'd10000;

  localparam int QUEUE_DEPTH = 4;

endpackage

@@ rtl/core/motion_progress_stuck_watchdog.sv @@
// path: an item passes the queue, stage 1 and the output register; items ahead of it in
// the queue and out_stall hold it back; throughput: one item per cycle unless out_stall
// holds a result, set by the single compare-and-update step of the back stage
// reset: synchronous active-low rst_n empties the queue and pipeline, clears the reference
// and loads the registers with their defaults; a config write takes effect once registered
module motion_progress_stuck_watchdog #(
  parameter int QUEUE_DEPTH = mpsw_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  mpsw_pkg::in_item_t                 in_data,
  output logic                               in_stall,
  output logic                               out_valid,
  output mpsw_pkg::out_item_t                out_data,
  input  logic                               out_stall,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpsw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  mpsw_pkg::cfg_t  cfg_r;
  mpsw_pkg::qent_t push_data, head;
  logic            q_full, q_push, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_threshold   <= mpsw_pkg::SPEED_THRESHOLD_RST;
      cfg_r.progress_distance <= mpsw_pkg::PROGRESS_DISTANCE_RST;
      cfg_r.stuck_time_limit  <= mpsw_pkg::STUCK_TIME_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mpsw_pkg::CFG_SPEED_THRESHOLD:   cfg_r.speed_threshold   <= cfg_data[14:0];
        mpsw_pkg::CFG_PROGRESS_DISTANCE: cfg_r.progress_distance <= cfg_data[30:0];
        mpsw_pkg::CFG_STUCK_TIME_LIMIT:  cfg_r.stuck_time_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  mpsw_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  mpsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  mpsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/mpsw_front.sv @@
module mpsw_front (
  input  logic                in_valid,
  input  mpsw_pkg::in_item_t  in_data,
  output logic                in_stall,
  input  logic                q_full,
  output logic                q_push,
  output mpsw_pkg::qent_t     q_data
);

  mpsw_pkg::cls_t cls;

  // priority chain up to the speed check
  always_comb begin
    if (in_data.paused) begin
      cls = mpsw_pkg::CLS_PAUSED;
    end else if (in_data.recovery_owns) begin
      cls = mpsw_pkg::CLS_RECOVERY;
    end else if (in_data.reflex_active) begin
      cls = mpsw_pkg::CLS_REFLEX;
    end else if (!in_data.goal_active) begin
      cls = mpsw_pkg::CLS_NOGOAL;
    end else if (!in_data.cmd_valid) begin
      cls = mpsw_pkg::CLS_NOCMD;
    end else begin
      cls = mpsw_pkg::CLS_CHECK;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.cls        = cls;
    q_data.pose_valid = in_data.pose_valid;
    q_data.pos_x      = in_data.pos_x;
    q_data.pos_y      = in_data.pos_y;
    q_data.cmd_vx     = in_data.cmd_vx;
    q_data.cmd_vy     = in_data.cmd_vy;
    q_data.now_ms     = in_data.now_ms;
  end

endmodule

@@ rtl/core/mpsw_queue.sv @@
module mpsw_queue #(
  parameter int DEPTH = mpsw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mpsw_pkg::qent_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output mpsw_pkg::qent_t  head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mpsw_pkg::qent_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/mpsw_back.sv @@
module mpsw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mpsw_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  mpsw_pkg::qent_t     q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mpsw_pkg::out_item_t out_data
);

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    abs_diff = d[32] ? 32'(33'd0 - d) : d[31:0];
  endfunction

  // squared thresholds, registered from the config registers
  logic [29:0] st2_r;
  logic [61:0] d2_r;

  // reference state
  logic               ref_valid_r;
  logic signed [31:0] ref_x_r;
  logic signed [31:0] ref_y_r;
  logic [47:0]        ref_time_r;
  logic               last_upd_r;

  // stage 1
  logic               s1_valid_r;
  logic               s1_pend_r;
  mpsw_pkg::cls_t     s1_cls_r;
  logic               s1_pose_valid_r;
  logic signed [31:0] s1_pos_x_r;
  logic signed [31:0] s1_pos_y_r;
  logic [47:0]        s1_now_r;
  logic [30:0]        s1_vx2_r;
  logic [30:0]        s1_vy2_r;
  logic [63:0]        s1_sqa_x_r, s1_sqa_y_r;
  logic [63:0]        s1_sqb_x_r, s1_sqb_y_r;

  // output register
  logic                out_valid_r;
  mpsw_pkg::out_item_t out_data_r;

  logic               adv;
  logic [31:0]        da_x, da_y, db_x, db_y;
  logic signed [31:0] vx2_full, vy2_full;

  logic [63:0]         sq_x, sq_y;
  logic [64:0]         dist_sum;
  logic [31:0]         spd_sum;
  logic                sel_b, moved, slow, stuck;
  logic [47:0]         elapsed;
  mpsw_pkg::out_item_t res;
  logic                set_pose, set_time, clr_valid;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  // candidate a: committed reference, candidate b: pose of the item ahead
  assign da_x     = abs_diff(q_head.pos_x, ref_x_r);
  assign da_y     = abs_diff(q_head.pos_y, ref_y_r);
  assign db_x     = abs_diff(q_head.pos_x, s1_pos_x_r);
  assign db_y     = abs_diff(q_head.pos_y, s1_pos_y_r);
  assign vx2_full = q_head.cmd_vx * q_head.cmd_vx;
  assign vy2_full = q_head.cmd_vy * q_head.cmd_vy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cls_r        <= q_head.cls;
      s1_pose_valid_r <= q_head.pose_valid;
      s1_pos_x_r      <= q_head.pos_x;
      s1_pos_y_r      <= q_head.pos_y;
      s1_now_r        <= q_head.now_ms;
      s1_vx2_r        <= vx2_full[30:0];
      s1_vy2_r        <= vy2_full[30:0];
      s1_sqa_x_r      <= da_x * da_x;
      s1_sqa_y_r      <= da_y * da_y;
      s1_sqb_x_r      <= db_x * db_x;
      s1_sqb_y_r      <= db_y * db_y;
    end
  end

  // stage 2: pick the candidate matching the reference after the item ahead
  assign sel_b    = s1_pend_r && last_upd_r;
  assign sq_x     = sel_b ? s1_sqb_x_r : s1_sqa_x_r;
  assign sq_y     = sel_b ? s1_sqb_y_r : s1_sqa_y_r;
  assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign moved    = dist_sum > {3'b0, d2_r};
  assign spd_sum  = {1'b0, s1_vx2_r} + {1'b0, s1_vy2_r};
  assign slow     = spd_sum < {2'b0, st2_r};
  assign elapsed  = s1_now_r - ref_time_r;
  assign stuck    = elapsed >= {16'b0, cfg.stuck_time_limit};

  always_comb begin
    res.error_level = 1'b0;
    res.reason_code = mpsw_pkg::RSN_PROGRESS;
    res.stuck_ms    = '0;
    set_pose        = 1'b0;
    set_time        = 1'b0;
    clr_valid       = 1'b0;
    unique case (s1_cls_r)
      mpsw_pkg::CLS_PAUSED: begin
        res.reason_code = mpsw_pkg::RSN_PAUSED;
        set_time        = 1'b1;
        set_pose        = s1_pose_valid_r;
        clr_valid       = !s1_pose_valid_r;
      end
      mpsw_pkg::CLS_RECOVERY: res.reason_code = mpsw_pkg::RSN_RECOVERY;
      mpsw_pkg::CLS_REFLEX:   res.reason_code = mpsw_pkg::RSN_REFLEX;
      mpsw_pkg::CLS_NOGOAL:   res.reason_code = mpsw_pkg::RSN_NOGOAL;
      mpsw_pkg::CLS_NOCMD:    res.reason_code = mpsw_pkg::RSN_NOCMD;
      mpsw_pkg::CLS_CHECK: begin
        if (slow) begin
          res.reason_code = mpsw_pkg::RSN_SLOW;
        end else if (!s1_pose_valid_r) begin
          res.reason_code = mpsw_pkg::RSN_NOPOSE;
        end else if (!ref_valid_r || moved) begin
          set_pose = 1'b1;
          set_time = 1'b1;
        end else if (stuck) begin
          res.error_level = 1'b1;
          res.reason_code = mpsw_pkg::RSN_STUCK;
          res.stuck_ms    = elapsed;
        end
      end
      default: res.reason_code = mpsw_pkg::RSN_PROGRESS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_r       <= mpsw_pkg::SPEED_SQ_RST;
      d2_r        <= mpsw_pkg::DIST_SQ_RST;
      ref_valid_r <= 1'b0;
      ref_x_r     <= '0;
      ref_y_r     <= '0;
      ref_time_r  <= '0;
      last_upd_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st2_r <= cfg.speed_threshold * cfg.speed_threshold;
      d2_r  <= cfg.progress_distance * cfg.progress_distance;
      if (adv) begin
        s1_valid_r  <= !q_empty;
        s1_pend_r   <= s1_valid_r;
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          last_upd_r <= set_pose;
          if (set_pose) begin
            ref_valid_r <= 1'b1;
            ref_x_r     <= s1_pos_x_r;
            ref_y_r     <= s1_pos_y_r;
          end else if (clr_valid) begin
            ref_valid_r <= 1'b0;
          end
          if (set_time) begin
            ref_time_r <= s1_now_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam logic [mpsw_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE_TICKS = 8;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  mpsw_pkg::in_item_t             in_data = '0;
  logic                           in_stall;
  logic                           out_valid;
  mpsw_pkg::out_item_t            out_data;
  logic                           out_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mpsw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;

  // watchdog thresholds as the block should hold them
  logic [14:0] speed_thr     = mpsw_pkg::SPEED_THRESHOLD_RST;
  logic [30:0] progress_dist = mpsw_pkg::PROGRESS_DISTANCE_RST;
  logic [31:0] stuck_limit   = mpsw_pkg::STUCK_TIME_LIMIT_RST;

  // progress reference
  logic               ref_set = 1'b0;
  logic signed [31:0] ref_px = '0;
  logic signed [31:0] ref_py = '0;
  logic [47:0]        ref_t = '0;

  // robot trajectory driving the random ticks
  logic signed [31:0] cur_x = '0;
  logic signed [31:0] cur_y = '0;
  logic [47:0]        cur_t = '0;

  mpsw_pkg::out_item_t awaited_reports[$];
  int mismatches = 0;
  int reports_checked = 0;
  int stuck_reports = 0;
  int ticks_sent = 0;
  int reg_writes = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  bit idle_mix = 1'b1;

  motion_progress_stuck_watchdog dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic mpsw_pkg::out_item_t judge_tick(input mpsw_pkg::in_item_t t);
    mpsw_pkg::out_item_t r;
    longint      vx, vy, ddx, ddy;
    logic [32:0] dx, dy;
    logic [65:0] sx, sy, d2;
    logic [47:0] elapsed;
    r = '0;
    r.reason_code = mpsw_pkg::RSN_PROGRESS;
    vx = t.cmd_vx;
    vy = t.cmd_vy;
    if (t.paused) begin
      ref_set = t.pose_valid;
      if (t.pose_valid) begin
        ref_px = t.pos_x;
        ref_py = t.pos_y;
      end
      ref_t = t.now_ms;
      r.reason_code = mpsw_pkg::RSN_PAUSED;
    end else if (t.recovery_owns) begin
      r.reason_code = mpsw_pkg::RSN_RECOVERY;
    end else if (t.reflex_active) begin
      r.reason_code = mpsw_pkg::RSN_REFLEX;
    end else if (!t.goal_active) begin
      r.reason_code = mpsw_pkg::RSN_NOGOAL;
    end else if (!t.cmd_valid) begin
      r.reason_code = mpsw_pkg::RSN_NOCMD;
    end else if (vx * vx + vy * vy < longint'(speed_thr) * speed_thr) begin
      r.reason_code = mpsw_pkg::RSN_SLOW;
    end else if (!t.pose_valid) begin
      r.reason_code = mpsw_pkg::RSN_NOPOSE;
    end else if (!ref_set) begin
      ref_set = 1'b1;
      ref_px = t.pos_x;
      ref_py = t.pos_y;
      ref_t = t.now_ms;
    end else begin
      ddx = longint'(t.pos_x) - longint'(ref_px);
      ddy = longint'(t.pos_y) - longint'(ref_py);
      dx = 33'((ddx < 0) ? -ddx : ddx);
      dy = 33'((ddy < 0) ? -ddy : ddy);
      sx = dx * dx;
      sy = dy * dy;
      d2 = progress_dist * progress_dist;
      if (sx + sy > d2) begin
        ref_px = t.pos_x;
        ref_py = t.pos_y;
        ref_t = t.now_ms;
      end else begin
        elapsed = t.now_ms - ref_t;
        if (elapsed >= stuck_limit) begin
          r.error_level = 1'b1;
          r.reason_code = mpsw_pkg::RSN_STUCK;
          r.stuck_ms = elapsed;
        end
      end
    end
    return r;
  endfunction

  // mostly healthy ticks along a drifting trajectory, with blocked, paused and pure-noise ones mixed in
  function automatic mpsw_pkg::in_item_t next_random_tick();
    mpsw_pkg::in_item_t t;
    logic [159:0] noise;
    int unsigned pick;
    int unsigned spn;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      return noise[$bits(mpsw_pkg::in_item_t)-1:0];
    end
    spn = (progress_dist >= 31'h4000_0000) ? 32'h4000_0000
                                            : progress_dist + progress_dist / 4 + 2;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      9: begin
        cur_x = $urandom;
        cur_y = $urandom;
      end
      default: begin
        cur_x = cur_x + $urandom_range(0, 2 * spn) - spn;
        cur_y = cur_y + $urandom_range(0, 2 * spn) - spn;
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: cur_t = cur_t + $urandom_range(0, stuck_limit / 8 + 1);
      6: cur_t = ref_t + stuck_limit + $urandom_range(0, 2) - 1;
      7, 8: cur_t = cur_t + $urandom_range(0, stuck_limit);
      default: cur_t = noise[159:112];
    endcase
    t = '0;
    t.goal_active = 1'b1;
    t.cmd_valid = 1'b1;
    t.pose_valid = 1'b1;
    t.pos_x = cur_x;
    t.pos_y = cur_y;
    t.now_ms = cur_t;
    t.cmd_vx = 16'($urandom_range(speed_thr, 15'h7FFF));
    if (noise[0]) begin
      t.cmd_vx = -t.cmd_vx;
    end
    t.cmd_vy = noise[1] ? noise[31:16] : 16'd0;
    if (pick < 15) begin
      t.paused = 1'b1;
      t.pose_valid = noise[2];
      {t.recovery_owns, t.reflex_active, t.goal_active, t.cmd_valid} = noise[6:3];
    end else if (pick < 27) begin
      case (pick % 6)
        0: t.recovery_owns = 1'b1;
        1: t.reflex_active = 1'b1;
        2: t.goal_active = 1'b0;
        3: begin
          t.cmd_valid = 1'b0;
          t.cmd_vx = noise[47:32];
          t.cmd_vy = noise[63:48];
        end
        4: begin
          t.pose_valid = 1'b0;
          t.pos_x = noise[95:64];
          t.pos_y = noise[127:96];
        end
        default: begin
          t.cmd_vx = 16'($urandom_range(0, speed_thr));
          t.cmd_vy = 16'sd0;
        end
      endcase
    end
    return t;
  endfunction

  task automatic send_tick(input mpsw_pkg::in_item_t t);
    mpsw_pkg::out_item_t want;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    want = judge_tick(t);
    awaited_reports = {awaited_reports, want};
    ticks_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic write_reg(input logic [mpsw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mpsw_pkg::CFG_SPEED_THRESHOLD:   speed_thr = value[14:0];
      mpsw_pkg::CFG_PROGRESS_DISTANCE: progress_dist = value[30:0];
      mpsw_pkg::CFG_STUCK_TIME_LIMIT:  stuck_limit = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_thresholds(input logic [31:0] spd, input logic [31:0] dist_val,
                                input logic [31:0] lim);
    hold_until_drained();
    write_reg(mpsw_pkg::CFG_SPEED_THRESHOLD, spd);
    write_reg(mpsw_pkg::CFG_PROGRESS_DISTANCE, dist_val);
    write_reg(mpsw_pkg::CFG_STUCK_TIME_LIMIT, lim);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if (idle_mix && i % 40 == 0) begin
        sender_gaps = $urandom_range(0, 2) != 0;
        receiver_stalls = $urandom_range(0, 2) != 0;
      end
      send_tick(next_random_tick());
    end
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic test_directed_ticks();
    mpsw_pkg::in_item_t t;
    t = '0;
    t.goal_active = 1'b1;
    t.cmd_valid = 1'b1;
    t.pose_valid = 1'b1;
    t.cmd_vx = 16'sd1000;
    t.now_ms = 48'd1000;
    send_tick(t);  // first pose arms the reference
    t.now_ms = 48'd5999;
    send_tick(t);
    t.now_ms = 48'd6000;
    send_tick(t);  // exactly on the stuck limit
    t.pos_x = 32'sd100;
    t.now_ms = 48'd6001;
    send_tick(t);  // displacement equal to the distance is no progress
    t.pos_x = 32'sd60;
    t.pos_y = 32'sd80;
    send_tick(t);
    t.pos_x = 32'sd61;
    t.now_ms = 48'd6002;
    send_tick(t);
    t.cmd_vx = 16'sd49;
    send_tick(t);  // just under the speed threshold
    t.cmd_vx = -16'sd30;
    t.cmd_vy = -16'sd40;
    t.now_ms = 48'd6003;
    send_tick(t);  // speed exactly on the threshold
    t.pose_valid = 1'b0;
    send_tick(t);
    t.pose_valid = 1'b1;
    t.cmd_valid = 1'b0;
    send_tick(t);
    t.cmd_valid = 1'b1;
    t.goal_active = 1'b0;
    send_tick(t);
    t.goal_active = 1'b1;
    t.reflex_active = 1'b1;
    send_tick(t);
    t.recovery_owns = 1'b1;
    t.goal_active = 1'b0;
    send_tick(t);
    t.paused = 1'b1;
    t.pos_x = 32'h8000_0000;
    t.pos_y = 32'h7FFF_FFFF;
    t.now_ms = 48'hFFFF_FFFF_FFFF;
    send_tick(t);  // pause re-arms at the corner, at the top of the time range
    t.paused = 1'b0;
    t.recovery_owns = 1'b0;
    t.reflex_active = 1'b0;
    t.goal_active = 1'b1;
    t.cmd_vx = 16'h8000;
    t.cmd_vy = 16'h8000;
    t.now_ms = 48'd4998;
    send_tick(t);
    t.now_ms = 48'd4999;
    send_tick(t);  // stuck across the time wrap
    t.pos_x = 32'h7FFF_FFFF;
    t.pos_y = 32'h8000_0000;
    t.cmd_vx = 16'sh7FFF;
    t.cmd_vy = 16'sh7FFF;
    send_tick(t);  // largest possible displacement
    t.paused = 1'b1;
    t.pose_valid = 1'b0;
    t.now_ms = 48'h1_0000_0000;
    send_tick(t);  // pause without pose drops the reference
    t.paused = 1'b0;
    t.pose_valid = 1'b1;
    t.now_ms = 48'h1_0000_1000;
    send_tick(t);
    t = '1;
    send_tick(t);
  endtask

  task automatic test_zero_thresholds();
    set_thresholds(32'd0, 32'd0, 32'd0);
    run_random_ticks(200);
  endtask

  // all-ones data also checks that the unused upper bits are dropped
  task automatic test_max_thresholds();
    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_ticks(200);
  endtask

  task automatic test_unused_register_index();
    hold_until_drained();
    write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
    write_reg(mpsw_pkg::CFG_SPEED_THRESHOLD, 32'd200);
    write_reg(CFG_IDX_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    run_random_ticks(150);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        set_thresholds($urandom, $urandom, $urandom);
      end else begin
        set_thresholds($urandom_range(0, 3000), $urandom_range(0, 20000),
                       $urandom_range(0, 30000));
      end
      run_random_ticks(100);
      hold_until_drained();
      run_random_ticks(100);
    end
  endtask

  task automatic test_unbroken_stream();
    set_thresholds($urandom_range(0, 1000), $urandom_range(0, 5000), $urandom_range(0, 20000));
    idle_mix = 1'b0;
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    run_random_ticks(300);
  endtask

  // report checker and receiver stall bursts
  always @(posedge clk) begin
    mpsw_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got level %0d reason %0d duration %0d",
                 $time, out_data.error_level, out_data.reason_code, out_data.stuck_ms);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("error_level", want.error_level, out_data.error_level);
        check_field("reason_code", want.reason_code, out_data.reason_code);
        check_field("stuck_ms", want.stuck_ms, out_data.stuck_ms);
        reports_checked++;
        if (want.reason_code == mpsw_pkg::RSN_STUCK) begin
          stuck_reports++;
        end
      end
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ends the run if no transfer happens on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d reports outstanding",
               $time, quiet_cycles, awaited_reports.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ticks();
    test_zero_thresholds();
    test_max_thresholds();
    test_unused_register_index();
    test_random_settings();
    test_unbroken_stream();
    hold_until_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    $display("%0d ticks under %0d threshold settings, %0d register writes",
             ticks_sent, settings_used, reg_writes);
    $display("%0d reports checked, %0d stuck errors among them, %0d mismatches, %0d missing",
             reports_checked, stuck_reports, mismatches, awaited_reports.size());
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mpsw_pkg.sv
rtl/core/mpsw_front.sv
rtl/core/mpsw_queue.sv
rtl/core/mpsw_back.sv
rtl/core/motion_progress_stuck_watchdog.sv
test/tb_top.sv
